// ===== rtl/aad_pkg.sv =====
// ----------------------------------------------------------------------------
// aad_pkg - shared types and constants of the adaptive arithmetic decoder
// Symbol alphabet, weight width, result status codes and sequencer types.
// ----------------------------------------------------------------------------
package aad_pkg;

  localparam int NUM_SYMBOLS = 257;
  localparam int SYM_W       = 9;
  localparam int WT_W        = 30;

  localparam logic [SYM_W-1:0] END_SYMBOL    = 9'd256;
  localparam logic [WT_W-1:0]  TOTAL_RST     = 30'd257;
  localparam logic [WT_W-1:0]  MAX_TOTAL_RST = 30'd65535;
  localparam logic [WT_W-1:0]  WEIGHT_RST    = 30'd1;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_FINISHED  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRIME,
    ST_DET_GO,
    ST_DET_WAIT,
    ST_SCAN,
    ST_LOW_GO,
    ST_LOW_WAIT,
    ST_HIGH_GO,
    ST_HIGH_WAIT,
    ST_RENORM,
    ST_OUT
  } dec_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic       wr;
    logic [7:0] wr_byte;
    logic       take;
  } fifo_cmd_t;

  typedef struct packed {
    logic full;
    logic enough;
    logic enough_next;
    logic bit_ready;
    logic bit_val;
  } fifo_stat_t;

endpackage

// ===== rtl/adaptive_arithmetic_decoder_core.sv =====
// ----------------------------------------------------------------------------
// adaptive_arithmetic_decoder_core - adaptive integer arithmetic decoder
// Decodes bytes from a compressed stream with an adaptive 257 symbol model.
// ----------------------------------------------------------------------------
// Every transfer in gives exactly one transfer out. tuser[0] selects the kind:
// a load transfer puts tdata into the byte queue (status 2 when full), a decode
// transfer returns one symbol (status 1 while fewer than REG_BITS bits wait,
// end_of_stream once the end symbol comes out, status 3 for anything after).
// Items are handled one at a time. A load that first completes REG_BITS queued
// bits also fills the tag, one bit a cycle, waiting for a ram read at each new
// queue byte. A decode runs the shared multiply/divide unit (one bit a cycle) and
// turns the weight chain once through the symbol scan; unless the end symbol comes
// out, it runs the unit twice more and renormalises, where each queue byte change
// waits for a ram read. The result then waits in the output state until the
// output register is free. max_total may be written only while the block is idle.
// ----------------------------------------------------------------------------
module adaptive_arithmetic_decoder_core #(
  parameter int REG_BITS   = 32,
  parameter int FIFO_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // max_total register
  input  logic        cfg_wr_en,
  input  logic [29:0] cfg_wr_data,
  // input transfers
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // compressed_byte
  input  logic [0:0]  s_axis_tuser,   // kind
  // result transfers
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // symbol
  output logic [2:0]  m_axis_tuser    // status[1:0], end_of_stream
);

  localparam int WT  = aad_pkg::WT_W;
  localparam int SW  = aad_pkg::SYM_W;
  localparam int NS  = aad_pkg::NUM_SYMBOLS;
  localparam int RW  = REG_BITS + 1;
  localparam int DW  = (RW > WT) ? RW : WT;
  localparam int PW  = RW + WT;
  localparam int CW  = $clog2(REG_BITS + 1);

  aad_pkg::dec_state_t state;
  aad_pkg::dec_state_t state_next;

  // coder state
  logic [REG_BITS-1:0] low;
  logic [REG_BITS-1:0] high;
  logic [REG_BITS-1:0] tag;
  logic [RW-1:0]       rng;
  logic [WT-1:0]       total;
  logic [WT-1:0]       max_total;
  logic                primed;
  logic                finished;

  // scan and arithmetic
  logic [PW-1:0]       det;
  logic [SW-1:0]       idx;
  logic [WT-1:0]       cum;
  logic                hit;
  logic [SW-1:0]       sym;
  logic [WT-1:0]       cum_s;
  logic [WT-1:0]       w_s;
  logic [REG_BITS-1:0] qlo;
  logic [CW-1:0]       cnt;

  // result held until the output register is free
  logic [7:0]          res_symbol;
  logic                res_eos;
  logic [1:0]          res_status;
  logic [7:0]          out_symbol;
  logic                out_eos;
  logic [1:0]          out_status;
  logic                out_valid;

  // weight chain
  logic [WT-1:0]       w [NS];
  logic                scan_shift;
  logic                bump;
  logic [WT-1:0]       cum_next;
  logic                hit_now;
  logic [SW-1:0]       scan_sym;
  logic                inc_ok;

  // renormalisation
  logic                top_eq;
  logic                e3;
  logic                ren_go;
  logic [REG_BITS-1:0] low_s;
  logic [REG_BITS-1:0] high_s;
  logic [REG_BITS-1:0] tag_s;

  // handshakes and units
  logic                accept;
  logic                kind;
  logic                out_free;
  aad_pkg::fifo_cmd_t  fcmd;
  aad_pkg::fifo_stat_t fstat;
  logic                md_start;
  logic [RW-1:0]       md_a;
  logic [WT-1:0]       md_b;
  logic                md_dec;
  logic [DW-1:0]       md_d;
  logic                md_done;
  logic [PW-1:0]       md_q;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign kind     = s_axis_tuser[0];
  assign out_free = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_symbol;
  assign m_axis_tuser  = {out_status, out_eos};

  aad_fifo #(.DEPTH(FIFO_DEPTH), .REG_BITS(REG_BITS)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .cmd  (fcmd),
    .stat (fstat)
  );

  aad_muldiv #(.AW(RW), .BW(WT), .DW(DW)) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .dec   (md_dec),
    .d     (md_d),
    .done  (md_done),
    .q     (md_q)
  );

  // ring of weight cells: cell 0 is the head seen by the scan, the tail
  // takes the head back with the adaptive increment for the decoded symbol
  for (genvar i = 0; i < NS; i++) begin : g_cell
    if (i == NS - 1) begin : g_tail
      aad_cell #(.W(WT)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (scan_shift),
        .bump  (bump),
        .w_in  (w[0]),
        .w_out (w[i])
      );
    end else begin : g_body
      aad_cell #(.W(WT)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (scan_shift),
        .bump  (1'b0),
        .w_in  (w[i+1]),
        .w_out (w[i])
      );
    end
  end

  // scan terms
  assign cum_next = cum + w[0];
  assign hit_now  = (state == aad_pkg::ST_SCAN) && !hit && (det < PW'(cum_next));
  assign inc_ok   = (total < max_total);
  assign scan_sym = hit ? sym : aad_pkg::END_SYMBOL;

  // renormalisation terms: equal msbs shift out, straddling the middle half scales
  assign top_eq = (low[REG_BITS-1] == high[REG_BITS-1]);
  assign e3     = !high[REG_BITS-2] && low[REG_BITS-2];
  assign ren_go = (cnt != CW'(REG_BITS)) && (top_eq || e3);

  always_comb begin
    low_s  = {low[REG_BITS-2:0], 1'b0};
    high_s = {high[REG_BITS-2:0], 1'b1};
    tag_s  = {tag[REG_BITS-2:0], fstat.bit_val};
    if (!top_eq) begin
      low_s[REG_BITS-1]  = 1'b0;
      high_s[REG_BITS-1] = 1'b1;
      tag_s[REG_BITS-1]  = ~tag_s[REG_BITS-1];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      aad_pkg::ST_IDLE: begin
        if (accept) begin
          if (finished) begin
            state_next = aad_pkg::ST_OUT;
          end else if (kind == aad_pkg::KIND_LOAD) begin
            if (!fstat.full && !primed && fstat.enough_next) begin
              state_next = aad_pkg::ST_PRIME;
            end else begin
              state_next = aad_pkg::ST_OUT;
            end
          end else if (primed && fstat.enough) begin
            state_next = aad_pkg::ST_DET_GO;
          end else begin
            state_next = aad_pkg::ST_OUT;
          end
        end
      end
      aad_pkg::ST_PRIME: begin
        if (fstat.bit_ready && (cnt == CW'(REG_BITS - 1))) state_next = aad_pkg::ST_OUT;
      end
      aad_pkg::ST_DET_GO:   state_next = aad_pkg::ST_DET_WAIT;
      aad_pkg::ST_DET_WAIT: begin
        if (md_done) state_next = aad_pkg::ST_SCAN;
      end
      aad_pkg::ST_SCAN: begin
        if (idx == aad_pkg::END_SYMBOL) begin
          state_next = (scan_sym == aad_pkg::END_SYMBOL) ? aad_pkg::ST_OUT
                                                         : aad_pkg::ST_LOW_GO;
        end
      end
      aad_pkg::ST_LOW_GO:   state_next = aad_pkg::ST_LOW_WAIT;
      aad_pkg::ST_LOW_WAIT: begin
        if (md_done) state_next = aad_pkg::ST_HIGH_GO;
      end
      aad_pkg::ST_HIGH_GO:   state_next = aad_pkg::ST_HIGH_WAIT;
      aad_pkg::ST_HIGH_WAIT: begin
        if (md_done) state_next = aad_pkg::ST_RENORM;
      end
      aad_pkg::ST_RENORM: begin
        if (!ren_go) state_next = aad_pkg::ST_OUT;
      end
      aad_pkg::ST_OUT: begin
        if (out_free) state_next = aad_pkg::ST_IDLE;
      end
      default: state_next = aad_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state == aad_pkg::ST_IDLE);
    scan_shift    = (state == aad_pkg::ST_SCAN);
    bump          = hit_now && (idx != aad_pkg::END_SYMBOL) && inc_ok;
    fcmd.wr       = accept && (kind == aad_pkg::KIND_LOAD) && !finished && !fstat.full;
    fcmd.wr_byte  = s_axis_tdata;
    fcmd.take     = fstat.bit_ready &&
                    ((state == aad_pkg::ST_PRIME) ||
                     ((state == aad_pkg::ST_RENORM) && ren_go));
    md_start      = 1'b0;
    md_a          = rng;
    md_b          = cum_s;
    md_dec        = 1'b0;
    md_d          = DW'(total);
    case (state)
      aad_pkg::ST_DET_GO: begin
        // scaled tag: ((offset + 1) * total - 1) / range
        md_start = 1'b1;
        md_a     = RW'(REG_BITS'(tag - low)) + RW'(1);
        md_b     = total;
        md_dec   = 1'b1;
        md_d     = DW'(rng);
      end
      aad_pkg::ST_LOW_GO: begin
        md_start = 1'b1;
        md_b     = cum_s - w_s;
      end
      aad_pkg::ST_HIGH_GO: begin
        md_start = 1'b1;
      end
      default: begin
        md_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= aad_pkg::ST_IDLE;
      low       <= '0;
      high      <= '1;
      tag       <= '0;
      total     <= aad_pkg::TOTAL_RST;
      max_total <= aad_pkg::MAX_TOTAL_RST;
      primed    <= 1'b0;
      finished  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        max_total <= cfg_wr_data;
      end
      // in the output state a free register is refilled below instead
      if (out_valid && m_axis_tready && (state != aad_pkg::ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        aad_pkg::ST_IDLE: begin
          if (accept) begin
            cnt        <= '0;
            res_symbol <= '0;
            res_eos    <= 1'b0;
            rng        <= RW'(REG_BITS'(high - low)) + RW'(1);
            if (finished) begin
              res_status <= aad_pkg::STATUS_FINISHED;
            end else if (kind == aad_pkg::KIND_LOAD) begin
              res_status <= fstat.full ? aad_pkg::STATUS_FULL : aad_pkg::STATUS_OK;
            end else begin
              res_status <= (primed && fstat.enough) ? aad_pkg::STATUS_OK
                                                     : aad_pkg::STATUS_UNDERFLOW;
            end
          end
        end
        aad_pkg::ST_PRIME: begin
          // tag fills from the first REG_BITS stream bits
          if (fstat.bit_ready) begin
            tag <= {tag[REG_BITS-2:0], fstat.bit_val};
            cnt <= cnt + 1'b1;
            if (cnt == CW'(REG_BITS - 1)) begin
              primed <= 1'b1;
            end
          end
        end
        aad_pkg::ST_DET_WAIT: begin
          if (md_done) begin
            det <= md_q;
            idx <= '0;
            cum <= '0;
            hit <= 1'b0;
            sym <= aad_pkg::END_SYMBOL;
          end
        end
        aad_pkg::ST_SCAN: begin
          // one weight a cycle passes the head; first cumulative sum above det wins
          idx <= idx + 1'b1;
          cum <= cum_next;
          if (hit_now) begin
            hit   <= 1'b1;
            sym   <= idx;
            cum_s <= cum_next;
            w_s   <= w[0];
          end
          if ((idx == aad_pkg::END_SYMBOL) && (scan_sym == aad_pkg::END_SYMBOL)) begin
            finished <= 1'b1;
            res_eos  <= 1'b1;
          end
        end
        aad_pkg::ST_LOW_WAIT: begin
          if (md_done) begin
            qlo <= md_q[REG_BITS-1:0];
          end
        end
        aad_pkg::ST_HIGH_WAIT: begin
          if (md_done) begin
            low  <= low + qlo;
            high <= low + md_q[REG_BITS-1:0] - REG_BITS'(1);
            cnt  <= '0;
          end
        end
        aad_pkg::ST_RENORM: begin
          if (ren_go) begin
            if (fstat.bit_ready) begin
              low  <= low_s;
              high <= high_s;
              tag  <= tag_s;
              cnt  <= cnt + 1'b1;
            end
          end else begin
            res_symbol <= sym[7:0];
            if (inc_ok) begin
              total <= total + WT'(1);
            end
          end
        end
        aad_pkg::ST_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_symbol <= res_symbol;
            out_eos    <= res_eos;
            out_status <= res_status;
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

endmodule

// ===== rtl/aad_ram.sv =====
// ----------------------------------------------------------------------------
// aad_ram - generic single write port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module aad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/aad_fifo.sv =====
// ----------------------------------------------------------------------------
// aad_fifo - compressed byte queue with msb-first bit reader
// Holds loaded bytes in a ram and hands out one stream bit per take.
// ----------------------------------------------------------------------------
module aad_fifo #(
  parameter int DEPTH    = 16,
  parameter int REG_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  aad_pkg::fifo_cmd_t cmd,
  output aad_pkg::fifo_stat_t stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int BW = FW + 4;

  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic [2:0]    bit_pos;
  logic          head_rdy;
  logic [7:0]    head_q;
  logic          wr_ok;
  logic          take_ok;
  logic          pop;
  logic [BW-1:0] bits_now;
  logic [BW-1:0] bits_next;

  aad_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (wr_ptr),
    .wdata (cmd.wr_byte),
    .raddr (rd_ptr),
    .rdata (head_q)
  );

  assign wr_ok   = cmd.wr && (fill != FW'(DEPTH));
  assign take_ok = cmd.take && (fill != '0);
  assign pop     = take_ok && (bit_pos == 3'd0);

  // buffered bits: whole bytes minus the bits already used from the head
  assign bits_now  = BW'({fill, 3'b000}) - BW'(3'd7 - bit_pos);
  assign bits_next = bits_now + BW'(8);

  assign stat.full        = (fill == FW'(DEPTH));
  assign stat.enough      = (fill != '0) && (bits_now >= BW'(REG_BITS));
  assign stat.enough_next = (bits_next >= BW'(REG_BITS));
  assign stat.bit_ready   = head_rdy || (fill == '0);
  assign stat.bit_val     = (fill != '0) && head_q[bit_pos];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fill     <= '0;
      bit_pos  <= 3'd7;
      head_rdy <= 1'b0;
    end else begin
      // head data is stale in the cycle after the read address or its entry changes
      head_rdy <= !(pop || (wr_ok && (wr_ptr == rd_ptr)));
      if (wr_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        fill   <= fill + 1'b1;
      end else if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        fill   <= fill - 1'b1;
      end
      if (take_ok) begin
        bit_pos <= bit_pos - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/aad_cell.sv =====
// ----------------------------------------------------------------------------
// aad_cell - one symbol weight cell of the rotating weight chain
// Takes its neighbour's weight on each shift, adding an optional bump.
// ----------------------------------------------------------------------------
module aad_cell #(
  parameter int W = 30
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  logic         bump,
  input  logic [W-1:0] w_in,
  output logic [W-1:0] w_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_out <= W'(aad_pkg::WEIGHT_RST);
    end else if (shift) begin
      w_out <= w_in + W'(bump);
    end
  end

endmodule

// ===== rtl/aad_muldiv.sv =====
// ----------------------------------------------------------------------------
// aad_muldiv - sequential multiply then divide
// Computes (a * b - dec) / d, one multiplier bit then one quotient bit a cycle.
// ----------------------------------------------------------------------------
module aad_muldiv #(
  parameter int AW = 33,
  parameter int BW = 30,
  parameter int DW = 33,
  localparam int PW = AW + BW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  input  logic          dec,
  input  logic [DW-1:0] d,
  output logic          done,
  output logic [PW-1:0] q
);

  localparam int CW = $clog2(PW + 1);

  aad_pkg::md_state_t state;
  aad_pkg::md_state_t state_next;

  logic [CW-1:0] cnt;
  logic [PW-1:0] acc;
  logic [PW-1:0] mcand;
  logic [BW-1:0] mplier;
  logic          dec_r;
  logic [DW-1:0] d_r;
  logic [DW-1:0] rem;
  logic [PW-1:0] sum;
  logic [DW:0]   trial;
  logic          ge;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      aad_pkg::MD_IDLE: begin
        if (start) state_next = aad_pkg::MD_MUL;
      end
      aad_pkg::MD_MUL: begin
        if (cnt == CW'(BW - 1)) state_next = aad_pkg::MD_DIV;
      end
      aad_pkg::MD_DIV: begin
        if (cnt == CW'(PW - 1)) state_next = aad_pkg::MD_DONE;
      end
      aad_pkg::MD_DONE: begin
        state_next = aad_pkg::MD_IDLE;
      end
      default: state_next = aad_pkg::MD_IDLE;
    endcase
  end

  // outputs and datapath terms
  always_comb begin
    done  = (state == aad_pkg::MD_DONE);
    q     = acc;
    sum   = acc + (mplier[0] ? mcand : '0);
    trial = {rem, acc[PW-1]};
    ge    = (trial >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aad_pkg::MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      aad_pkg::MD_IDLE: begin
        if (start) begin
          acc    <= '0;
          mcand  <= PW'(a);
          mplier <= b;
          dec_r  <= dec;
          d_r    <= d;
          cnt    <= '0;
        end
      end
      aad_pkg::MD_MUL: begin
        mcand  <= {mcand[PW-2:0], 1'b0};
        mplier <= mplier >> 1;
        if (cnt == CW'(BW - 1)) begin
          acc <= sum - PW'(dec_r);
          cnt <= '0;
          rem <= '0;
        end else begin
          acc <= sum;
          cnt <= cnt + 1'b1;
        end
      end
      aad_pkg::MD_DIV: begin
        // restoring step: dividend bits shift out as quotient bits shift in
        rem <= ge ? DW'(trial - {1'b0, d_r}) : trial[DW-1:0];
        acc <= {acc[PW-2:0], ge};
        cnt <= cnt + 1'b1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

// ===== dv/tb_adaptive_arithmetic_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_arithmetic_decoder_core - self-checking bench for the decoder
// A queue-fed driver sends load and decode transfers in random bursts while
// the result side stalls on its own pattern. A built-in model of the adaptive
// decoder predicts every result, and the monitor compares each field in order.
// ----------------------------------------------------------------------------
module tb_adaptive_arithmetic_decoder_core;

  localparam int REG_BITS   = 32;
  localparam int FIFO_DEPTH = 16;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_val;
  } stream_item_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       eos;
    logic [1:0] status;
  } decode_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [29:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // compressed_byte
  logic [0:0]  s_axis_tuser = '0;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // symbol
  logic [2:0]  m_axis_tuser;        // status[1:0], end_of_stream

  adaptive_arithmetic_decoder_core #(
    .REG_BITS  (REG_BITS),
    .FIFO_DEPTH(FIFO_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // decoder model state
  // --------------------------------------------------------------------------
  bit [31:0] lo_bnd, hi_bnd, tag_reg;
  bit [29:0] sym_wt [aad_pkg::NUM_SYMBOLS];
  bit [29:0] wt_total;
  bit [29:0] wt_limit;
  bit [7:0]  byte_q [$];
  int        bit_pos;
  bit        primed;
  bit        finished;

  stream_item_t   pending_items [$];
  decode_result_t expected_results [$];

  int mismatches = 0;
  int results_seen = 0;

  function automatic int bits_queued();
    if (byte_q.size() == 0) return 0;
    return byte_q.size() * 8 - (7 - bit_pos);
  endfunction

  // next stream bit, msb first; zero once the queue runs dry
  function automatic bit pull_bit();
    bit b;
    if (byte_q.size() == 0) return 1'b0;
    b = byte_q[0][bit_pos];
    if (bit_pos == 0) begin
      void'(byte_q.pop_front());
      bit_pos = 7;
    end else begin
      bit_pos--;
    end
    return b;
  endfunction

  function automatic void shift_bounds();
    lo_bnd  = lo_bnd << 1;
    hi_bnd  = {hi_bnd[30:0], 1'b1};
    tag_reg = {tag_reg[30:0], pull_bit()};
  endfunction

  // symbol the scan would pick for the current tag, without touching state
  function automatic int scan_symbol(output bit [63:0] cum_out);
    bit [63:0] span, offs, target, cum;
    int s;
    span   = {32'b0, hi_bnd - lo_bnd} + 64'd1;
    offs   = {32'b0, tag_reg - lo_bnd};
    target = ((offs + 64'd1) * wt_total - 64'd1) / span;
    cum    = 0;
    s      = int'(aad_pkg::END_SYMBOL);
    for (int i = 0; i < aad_pkg::NUM_SYMBOLS; i++) begin
      cum += sym_wt[i];
      if (target < cum) begin
        s = i;
        break;
      end
    end
    cum_out = cum;
    return s;
  endfunction

  function automatic bit decode_would_end();
    bit [63:0] c;
    if (finished || !primed || bits_queued() < REG_BITS) return 1'b0;
    return scan_symbol(c) == int'(aad_pkg::END_SYMBOL);
  endfunction

  // one step of the adaptive decoder
  function automatic decode_result_t decoder_step(stream_item_t it);
    decode_result_t r;
    bit [63:0] span, cum, w, base;
    int s;
    r = '0;
    if (finished) begin
      r.status = aad_pkg::STATUS_FINISHED;
      return r;
    end
    if (it.kind == aad_pkg::KIND_LOAD) begin
      if (byte_q.size() >= FIFO_DEPTH) begin
        r.status = aad_pkg::STATUS_FULL;
        return r;
      end
      byte_q.push_back(it.byte_val);
      if (!primed && bits_queued() >= REG_BITS) begin
        for (int i = 0; i < REG_BITS; i++) tag_reg = {tag_reg[30:0], pull_bit()};
        primed = 1'b1;
      end
      return r;
    end
    if (!primed || bits_queued() < REG_BITS) begin
      r.status = aad_pkg::STATUS_UNDERFLOW;
      return r;
    end
    span = {32'b0, hi_bnd - lo_bnd} + 64'd1;
    s = scan_symbol(cum);
    if (s == int'(aad_pkg::END_SYMBOL)) begin
      finished = 1'b1;
      r.eos = 1'b1;
      return r;
    end
    w    = sym_wt[s];
    base = lo_bnd;
    lo_bnd = 32'(base + (span * (cum - w)) / wt_total);
    hi_bnd = 32'(base + (span * cum) / wt_total - 64'd1);
    // renormalisation: matching msbs, then the middle-half straddle case
    for (int n = 0; n < REG_BITS; n++) begin
      if (lo_bnd[31] == hi_bnd[31]) begin
        shift_bounds();
      end else if (!hi_bnd[30] && lo_bnd[30]) begin
        shift_bounds();
        lo_bnd[31]  = 1'b0;
        hi_bnd[31]  = 1'b1;
        tag_reg[31] = ~tag_reg[31];
      end else begin
        break;
      end
    end
    if (wt_total < wt_limit) begin
      sym_wt[s] = sym_wt[s] + 30'd1;
      wt_total  = wt_total + 30'd1;
    end
    r.sym = 8'(s);
    return r;
  endfunction

  function automatic void queue_item(logic kind, logic [7:0] b);
    stream_item_t it;
    it.kind = kind;
    it.byte_val = b;
    expected_results.push_back(decoder_step(it));
    pending_items.push_back(it);
  endfunction

  // --------------------------------------------------------------------------
  // driver: bursts of transfers with random gaps, changes on the falling edge
  // --------------------------------------------------------------------------
  logic in_fire = 1'b0;
  int   burst_left = 4;
  int   gap_left = 0;

  always @(posedge clk) in_fire <= s_axis_tvalid && s_axis_tready;

  always @(negedge clk) begin
    stream_item_t it;
    logic nv;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        nv = 1'b1;
        s_axis_tdata <= it.byte_val;
        s_axis_tuser <= it.kind;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // --------------------------------------------------------------------------
  // receiver stall pattern, with one long hold-off to back the block up
  // --------------------------------------------------------------------------
  int  ready_duty = 100;
  int  duty_cycles = 0;
  int  hold_cycles = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 60) begin
      hold_done = 1'b1;
      hold_cycles = 3000;
      m_axis_tready <= 1'b0;
    end else begin
      if (duty_cycles == 0) begin
        duty_cycles = $urandom_range(50, 400);
        case ($urandom_range(0, 2))
          0: ready_duty = 100;
          1: ready_duty = 70;
          default: ready_duty = 25;
        endcase
      end
      duty_cycles--;
      m_axis_tready <= ($urandom_range(0, 99) < ready_duty);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: compare every result transfer with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    decode_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got.sym    = m_axis_tdata;
      got.eos    = m_axis_tuser[0];
      got.status = m_axis_tuser[2:1];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: symbol %0d eos %0d status %0d",
                   got.sym, got.eos, got.status);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: exp sym %0d eos %0d st %0d, got sym %0d eos %0d st %0d",
                     results_seen, want.sym, want.eos, want.status,
                     got.sym, got.eos, got.status);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  int idle_count = 0;

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_count = 0;
    else
      idle_count++;
    if (idle_count >= IDLE_LIMIT) begin
      $display("adaptive_arithmetic_decoder_core test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [29:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    wt_limit = v;
  endtask

  // mostly well-formed traffic: keep bits flowing, steer clear of the end
  task automatic random_phase(int count);
    logic kind;
    int   bits;
    for (int n = 0; n < count; n++) begin
      bits = bits_queued();
      if (!primed || bits < REG_BITS)
        kind = ($urandom_range(0, 9) == 0) ? aad_pkg::KIND_DECODE : aad_pkg::KIND_LOAD;
      else if (byte_q.size() >= FIFO_DEPTH)
        kind = ($urandom_range(0, 6) == 0) ? aad_pkg::KIND_LOAD : aad_pkg::KIND_DECODE;
      else
        kind = $urandom_range(0, 1) ? aad_pkg::KIND_DECODE : aad_pkg::KIND_LOAD;
      if (kind == aad_pkg::KIND_DECODE && decode_would_end()) kind = aad_pkg::KIND_LOAD;
      queue_item(kind, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int n;
    lo_bnd = '0;
    hi_bnd = '1;
    tag_reg = '0;
    foreach (sym_wt[i]) sym_wt[i] = aad_pkg::WEIGHT_RST;
    wt_total = aad_pkg::TOTAL_RST;
    wt_limit = aad_pkg::MAX_TOTAL_RST;
    bit_pos = 7;
    primed = 1'b0;
    finished = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: smallest limit, decode before priming, priming, full queue
    write_limit(30'd258);
    queue_item(aad_pkg::KIND_DECODE, 8'h00);
    queue_item(aad_pkg::KIND_LOAD, 8'h00);
    queue_item(aad_pkg::KIND_LOAD, 8'hFF);
    queue_item(aad_pkg::KIND_LOAD, 8'hA5);
    queue_item(aad_pkg::KIND_DECODE, 8'hFF);
    queue_item(aad_pkg::KIND_LOAD, 8'h5A);
    for (int i = 0; i < 16; i++) queue_item(aad_pkg::KIND_LOAD, 8'($urandom_range(0, 255)));
    for (int i = 0; i < 3; i++)
      if (!decode_would_end()) queue_item(aad_pkg::KIND_DECODE, 8'h00);
    wait_drained();

    // random phases over several limits; the first one also sees the hold-off
    write_limit(30'h3FFF_FFFF);
    random_phase(300);
    wait_drained();
    write_limit(30'($urandom_range(258, 2000)));
    random_phase(300);
    wait_drained();
    write_limit(30'd65535);
    random_phase(250);
    wait_drained();

    // drive the stream to its end with all-ones bytes, then items after it
    n = 0;
    while (!finished && n < 400) begin
      if (byte_q.size() < FIFO_DEPTH &&
          (!primed || bits_queued() < REG_BITS || $urandom_range(0, 1)))
        queue_item(aad_pkg::KIND_LOAD, 8'hFF);
      else
        queue_item(aad_pkg::KIND_DECODE, 8'hFF);
      n++;
    end
    queue_item(aad_pkg::KIND_LOAD, 8'h3C);
    queue_item(aad_pkg::KIND_DECODE, 8'h00);
    queue_item(aad_pkg::KIND_LOAD, 8'hFF);
    queue_item(aad_pkg::KIND_DECODE, 8'hFF);

    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("adaptive_arithmetic_decoder_core test passed");
    end else begin
      $display("adaptive_arithmetic_decoder_core test failed");
    end
    $finish;
  end

endmodule
